[sv/bitmap_first_fit_allocator_core_macros.svh]
// ----------------------------------------------------------------------------
// Bitmap first-fit allocator assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BFA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define BFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/bfa_pkg.sv]
// ----------------------------------------------------------------------------
// Bitmap first-fit allocator package
// Shared constants, status codes and state encoding.
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam int POOL_BYTES_DFLT = 4096;
    localparam int WORD_BYTES_DFLT = 2;

    localparam int ROW_BITS    = 32;   // map bits per memory row
    localparam int SIZE_W      = 16;
    localparam int OFFSET_W    = 12;
    localparam int NEED_W      = 17;   // rounded size, up to 65536
    localparam int SPAN_W      = 18;   // offset + rounded size
    localparam int COUNT_W     = 13;
    localparam int COUNT_MAX   = 8191;
    localparam int LIMIT_W     = 13;
    localparam int LIMIT_RST   = 1024;
    localparam int RECIP_SHIFT = 20;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // register index, taken from paddr[APB_AW-1:2]
    localparam logic CFG_MAX_REQ = 1'b0;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STAT_DONE     = 2'd0,
        STAT_REJECT   = 2'd1,
        STAT_NO_SPACE = 2'd2,
        STAT_IGNORED  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QUOT,
        ST_NEED,
        ST_SETUP,
        ST_SCAN,
        ST_RANGE_RD,
        ST_RANGE,
        ST_RESP
    } t_state;

endpackage

[sv/bitmap_first_fit_allocator_core.sv]
// ----------------------------------------------------------------------------
// Bitmap first-fit allocator core
// One occupancy bit per pool byte, held in a 32-bit-wide map memory.
// Allocate scans the map for the first free run and marks it; free clears a
// run. Both keep a saturating count of bytes in use.
//
//   channel | direction | handshake          | word
//   --------+-----------+--------------------+----------------------------------
//   request | in        | i_valid / o_ready  | req_type, size_bytes, block_offset
//   result  | out       | o_valid / i_ready  | status, start_offset, bytes_used
//   config  | in        | APB psel / penable | max_request_bytes at index 0
//
// Rejected or ignored requests go straight from idle to the response state.
// Allocate rounds the size, then scans and marks one map row per cycle
// through the single read port; free rounds the size and clears its rows.
// After reset a clearing pass writes every map row before the first
// request is taken.
// A stalled result holds in the output register; the next request is taken
// meanwhile and waits at its own result until the register drains.
// ----------------------------------------------------------------------------
module bitmap_first_fit_allocator_core #(
    parameter int POOL_BYTES = bfa_pkg::POOL_BYTES_DFLT,
    parameter int WORD_BYTES = bfa_pkg::WORD_BYTES_DFLT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_req_type,
    input  logic [bfa_pkg::SIZE_W-1:0]    i_size_bytes,
    input  logic [bfa_pkg::OFFSET_W-1:0]  i_block_offset,

    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_status,
    output logic [bfa_pkg::OFFSET_W-1:0]  o_start_offset,
    output logic [bfa_pkg::COUNT_W-1:0]   o_bytes_used,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bfa_pkg::APB_AW-1:0]    paddr,
    input  logic [bfa_pkg::APB_DW-1:0]    pwdata,
    output logic [bfa_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import bfa_pkg::*;

    localparam int ROW_W     = ROW_BITS;
    localparam int RSEL_W    = $clog2(ROW_W);
    localparam int LA_W      = RSEL_W + 1;
    localparam int NROWS     = (POOL_BYTES + ROW_W - 1) / ROW_W;
    localparam int RIW       = (NROWS > 1) ? $clog2(NROWS) : 1;
    localparam int PW        = $clog2(POOL_BYTES + 1);
    localparam int LAST_BITS = POOL_BYTES - (NROWS - 1) * ROW_W;
    localparam int RECIP     = (1 << RECIP_SHIFT) / WORD_BYTES;
    localparam int MUL_W     = NEED_W + RECIP_SHIFT + 1;

    localparam logic [RIW-1:0]     LAST_ROW = RIW'(NROWS - 1);
    localparam logic [NEED_W-1:0]  WB_N     = NEED_W'(WORD_BYTES);
    localparam logic [NEED_W-1:0]  WB_M1    = NEED_W'(WORD_BYTES - 1);
    localparam logic [SPAN_W-1:0]  POOL_X   = SPAN_W'(POOL_BYTES);
    localparam logic [COUNT_W-1:0] CNT_SAT  = COUNT_W'(COUNT_MAX);

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    t_state               r_state, n_state;
    logic [RIW-1:0]       r_row, n_row;
    logic [LIMIT_W-1:0]   r_max;
    logic [COUNT_W-1:0]   r_used, n_used;
    logic                 r_out_valid, n_out_valid;

    logic                 r_kind, n_kind;
    logic [SIZE_W-1:0]    r_size, n_size;
    logic [OFFSET_W-1:0]  r_off, n_off;
    logic [NEED_W-1:0]    r_quot, n_quot;
    logic [NEED_W-1:0]    r_need, n_need;
    logic [NEED_W-1:0]    r_rem, n_rem;
    logic [PW-1:0]        r_start, n_start;
    logic [PW-1:0]        r_lo, n_lo;
    logic [PW-1:0]        r_hi_m1, n_hi_m1;
    logic                 r_set, n_set;
    t_status              r_res_status, n_res_status;
    logic [PW-1:0]        r_res_start, n_res_start;
    t_status              r_out_status;
    logic [OFFSET_W-1:0]  r_out_start;
    logic [COUNT_W-1:0]   r_out_used;

    // ------------------------------------------------------------------
    // map memory: one write port, one registered read port
    // ------------------------------------------------------------------
    logic [ROW_W-1:0]     mem [NROWS];
    logic [ROW_W-1:0]     r_rd;
    logic                 mem_re, mem_we;
    logic [RIW-1:0]       mem_ra, mem_wa;
    logic [ROW_W-1:0]     mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= mem[mem_ra];
        end
    end

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    logic cfg_wr;
    logic cfg_idx;

    assign cfg_idx = paddr[APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = (cfg_idx == CFG_MAX_REQ) ? APB_DW'(r_max) : '0;

    // ------------------------------------------------------------------
    // size rounding: reciprocal multiply, then one correction step
    // ------------------------------------------------------------------
    logic [NEED_W-1:0] x_pad;
    logic [MUL_W-1:0]  prod;
    logic [NEED_W-1:0] q_mul;
    logic [NEED_W-1:0] q_rem;
    logic [NEED_W-1:0] round_need;

    assign x_pad      = NEED_W'(r_size) + WB_M1;
    assign prod       = MUL_W'(x_pad) * MUL_W'(RECIP);
    assign q_mul      = r_quot * WB_N;
    assign q_rem      = x_pad - q_mul;
    assign round_need = q_mul + ((q_rem >= WB_N) ? WB_N : '0);

    // ------------------------------------------------------------------
    // row scan: last used position per bit by prefix, then first fit
    // la value is index+1 of the last used bit at or below p, 0 if none
    // ------------------------------------------------------------------
    logic [PW-1:0]     row_base;
    logic [ROW_W-1:0]  row_free;
    logic [LA_W-1:0]   la [RSEL_W+1][ROW_W];
    logic [ROW_W-1:0]  row_hit;
    logic              scan_hit;
    logic [RSEL_W-1:0] scan_pos;
    logic [PW-1:0]     scan_start;
    logic [LA_W-1:0]   la_pos;
    logic [LA_W-1:0]   la_end;

    assign row_base = PW'({r_row, RSEL_W'(0)});

    always_comb begin
        for (int p = 0; p < ROW_W; p++) begin
            row_free[p] = ~r_rd[p] && ((r_row != LAST_ROW) || (p < LAST_BITS));
            la[0][p]    = row_free[p] ? '0 : LA_W'(p + 1);
        end
        for (int k = 0; k < RSEL_W; k++) begin
            for (int p = 0; p < ROW_W; p++) begin
                if ((p >= (1 << k)) && (la[k][p] == '0)) begin
                    la[k+1][p] = la[k][p - (1 << k)];
                end else begin
                    la[k+1][p] = la[k][p];
                end
            end
        end
        for (int p = 0; p < ROW_W; p++) begin
            if (la[RSEL_W][p] == '0) begin
                row_hit[p] = (NEED_W'(p + 1) >= r_rem);
            end else begin
                row_hit[p] = (NEED_W'(LA_W'(p + 1) - la[RSEL_W][p]) >= r_need);
            end
        end
    end

    always_comb begin
        scan_hit = 1'b0;
        scan_pos = '0;
        for (int p = ROW_W - 1; p >= 0; p--) begin
            if (row_hit[p]) begin
                scan_hit = 1'b1;
                scan_pos = RSEL_W'(p);
            end
        end
    end

    assign la_pos     = la[RSEL_W][scan_pos];
    assign la_end     = la[RSEL_W][ROW_W-1];
    assign scan_start = (la_pos == '0) ? r_start : row_base + PW'(la_pos);

    // ------------------------------------------------------------------
    // range pass: bit mask of [lo, hi_m1] within the current row
    // ------------------------------------------------------------------
    logic [RIW-1:0]    lo_row, hi_row;
    logic [RSEL_W-1:0] mask_lb, mask_ub;
    logic [ROW_W-1:0]  range_mask;

    assign lo_row  = r_lo[RSEL_W +: RIW];
    assign hi_row  = r_hi_m1[RSEL_W +: RIW];
    assign mask_lb = (r_row == lo_row) ? r_lo[RSEL_W-1:0] : '0;
    assign mask_ub = (r_row == hi_row) ? r_hi_m1[RSEL_W-1:0] : '1;

    always_comb begin
        for (int p = 0; p < ROW_W; p++) begin
            range_mask[p] = (RSEL_W'(p) >= mask_lb) && (RSEL_W'(p) <= mask_ub);
        end
    end

    // ------------------------------------------------------------------
    // free span and alloc mark span
    // ------------------------------------------------------------------
    logic [SPAN_W-1:0] free_end;
    logic [SPAN_W-1:0] free_hi;
    logic [SPAN_W-1:0] free_lo;
    logic [SPAN_W-1:0] free_hi_m1;
    logic [SPAN_W-1:0] mark_hi_m1;
    logic [SPAN_W-1:0] used_sum;
    logic [PW+OFFSET_W-1:0] start_ext;

    assign free_lo    = SPAN_W'(r_off);
    assign free_end   = free_lo + SPAN_W'(r_need);
    assign free_hi    = (free_end > POOL_X) ? POOL_X : free_end;
    assign free_hi_m1 = free_hi - 1'b1;
    assign mark_hi_m1 = SPAN_W'(scan_start) + SPAN_W'(r_need) - 1'b1;
    assign used_sum   = SPAN_W'(r_used) + SPAN_W'(r_need);
    assign start_ext  = (PW+OFFSET_W)'(r_res_start);

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        n_used       = r_used;
        n_out_valid  = r_out_valid;
        n_kind       = r_kind;
        n_size       = r_size;
        n_off        = r_off;
        n_quot       = r_quot;
        n_need       = r_need;
        n_rem        = r_rem;
        n_start      = r_start;
        n_lo         = r_lo;
        n_hi_m1      = r_hi_m1;
        n_set        = r_set;
        n_res_status = r_res_status;
        n_res_start  = r_res_start;
        mem_re       = 1'b0;
        mem_ra       = r_row;
        mem_we       = 1'b0;
        mem_wa       = r_row;
        mem_wd       = '0;
        o_ready      = 1'b0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                n_row  = r_row + 1'b1;
                if (r_row == LAST_ROW) begin
                    n_row   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_kind       = i_req_type;
                    n_size       = i_size_bytes;
                    n_off        = i_block_offset;
                    n_res_status = STAT_DONE;
                    n_res_start  = '0;
                    n_state      = ST_QUOT;
                    if (i_req_type == REQ_FREE) begin
                        if (i_size_bytes == '0) begin
                            n_res_status = STAT_IGNORED;
                            n_state      = ST_RESP;
                        end
                    end else if ((i_size_bytes == '0) ||
                                 (SIZE_W'(r_max) < i_size_bytes)) begin
                        n_res_status = STAT_REJECT;
                        n_state      = ST_RESP;
                    end
                end
            end
            ST_QUOT: begin
                n_quot  = prod[RECIP_SHIFT +: NEED_W];
                n_state = ST_NEED;
            end
            ST_NEED: begin
                n_need  = round_need;
                n_state = ST_SETUP;
            end
            ST_SETUP: begin
                if (r_kind == REQ_ALLOC) begin
                    n_rem   = r_need;
                    n_start = '0;
                    n_row   = '0;
                    mem_re  = 1'b1;
                    mem_ra  = '0;
                    n_state = ST_SCAN;
                end else if (free_lo >= free_hi) begin
                    n_state = ST_RESP;
                end else begin
                    n_lo    = free_lo[PW-1:0];
                    n_hi_m1 = free_hi_m1[PW-1:0];
                    n_set   = 1'b0;
                    n_state = ST_RANGE_RD;
                end
            end
            ST_SCAN: begin
                if (scan_hit) begin
                    n_lo        = scan_start;
                    n_hi_m1     = mark_hi_m1[PW-1:0];
                    n_res_start = scan_start;
                    n_set       = 1'b1;
                    n_state     = ST_RANGE_RD;
                end else begin
                    // carry the trailing free run into the next row
                    if (la_end == '0) begin
                        n_rem = r_rem - NEED_W'(ROW_W);
                    end else begin
                        n_start = row_base + PW'(la_end);
                        n_rem   = r_need - NEED_W'(LA_W'(ROW_W) - la_end);
                    end
                    if (r_row == LAST_ROW) begin
                        n_res_status = STAT_NO_SPACE;
                        n_state      = ST_RESP;
                    end else begin
                        mem_re = 1'b1;
                        mem_ra = r_row + 1'b1;
                        n_row  = r_row + 1'b1;
                    end
                end
            end
            ST_RANGE_RD: begin
                mem_re  = 1'b1;
                mem_ra  = lo_row;
                n_row   = lo_row;
                n_state = ST_RANGE;
            end
            ST_RANGE: begin
                mem_we = 1'b1;
                mem_wd = r_set ? (r_rd | range_mask) : (r_rd & ~range_mask);
                if (r_row == hi_row) begin
                    n_state = ST_RESP;
                end else begin
                    mem_re = 1'b1;
                    mem_ra = r_row + 1'b1;
                    n_row  = r_row + 1'b1;
                end
            end
            ST_RESP: begin
                if (!r_out_valid || i_ready) begin
                    if (r_res_status == STAT_DONE) begin
                        if (r_kind == REQ_ALLOC) begin
                            n_used = (used_sum > SPAN_W'(CNT_SAT)) ?
                                     CNT_SAT : used_sum[COUNT_W-1:0];
                        end else begin
                            n_used = (NEED_W'(r_used) > r_need) ?
                                     (r_used - r_need[COUNT_W-1:0]) : '0;
                        end
                    end
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_row       <= '0;
            r_max       <= LIMIT_W'(LIMIT_RST);
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
            if (cfg_wr && (cfg_idx == CFG_MAX_REQ)) begin
                r_max <= pwdata[LIMIT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_size       <= n_size;
        r_off        <= n_off;
        r_quot       <= n_quot;
        r_need       <= n_need;
        r_rem        <= n_rem;
        r_start      <= n_start;
        r_lo         <= n_lo;
        r_hi_m1      <= n_hi_m1;
        r_set        <= n_set;
        r_res_status <= n_res_status;
        r_res_start  <= n_res_start;
        if ((r_state == ST_RESP) && (!r_out_valid || i_ready)) begin
            r_out_status <= r_res_status;
            r_out_start  <= start_ext[OFFSET_W-1:0];
            r_out_used   <= n_used;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_start_offset = r_out_start;
    assign o_bytes_used   = r_out_used;

endmodule

[sv/bfa_checker.sv]
// ----------------------------------------------------------------------------
// Bitmap first-fit allocator port checker
// Watches the top-level ports; bound to every instance of the core.
// ----------------------------------------------------------------------------
`include "bitmap_first_fit_allocator_core_macros.svh"

module bfa_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [1:0]                    o_status,
    input logic [bfa_pkg::OFFSET_W-1:0]  o_start_offset,
    input logic [bfa_pkg::COUNT_W-1:0]   o_bytes_used,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [bfa_pkg::APB_AW-1:0]    paddr,
    input logic [bfa_pkg::APB_DW-1:0]    pwdata,
    input logic [bfa_pkg::APB_DW-1:0]    prdata,
    input logic                          pready
);
    import bfa_pkg::*;

    logic                          req_acc;
    logic                          lim_wr;
    logic                          sel0;
    logic [LIMIT_W-1:0]            cfg_wd;
    logic [LIMIT_W-1:0]            cfg_rd;
    logic                          out_stall;
    logic                          fail_out;
    logic [OFFSET_W+COUNT_W+1:0]   rsp;

    assign req_acc   = i_valid && o_ready;
    assign sel0      = (paddr[APB_AW-1:2] == CFG_MAX_REQ);
    assign lim_wr    = psel && penable && pwrite && pready && sel0;
    assign cfg_wd    = pwdata[LIMIT_W-1:0];
    assign cfg_rd    = prdata[LIMIT_W-1:0];
    assign out_stall = o_valid && !i_ready;
    assign fail_out  = o_valid && (o_status != STAT_DONE);
    assign rsp       = {o_status, o_start_offset, o_bytes_used};

    // one request in work at a time
    `BFA_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, req_acc, !o_ready, "taken while busy")

    // a result shows up only after the block went busy
    `BFA_ASSERT_IMP(a_result_has_req, i_clk, i_rst_n, $rose(o_valid), $past(!o_ready), "orphan")

    // stalled result holds
    `BFA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_valid && $stable(rsp), "moved")

    // only a successful request carries a start offset
    `BFA_ASSERT_IMP(a_start_zero, i_clk, i_rst_n, fail_out, o_start_offset == '0, "offset")

    // limit register reads back what was written
    `BFA_ASSERT_NEXT(a_lim_rb, i_clk, i_rst_n, lim_wr, !sel0 || (cfg_rd == $past(cfg_wd)), "rb")

endmodule

bind bitmap_first_fit_allocator_core bfa_checker u_bfa_checker (.*);

[tb/tb_bitmap_first_fit_allocator_core.sv]
// ----------------------------------------------------------------------------
// Bitmap first-fit allocator core testbench
// Drives allocate and free requests and checks each result word against a
// first-fit predictor that keeps its own occupancy map, byte count and size
// limit. Covers directed corner cases, size limit extremes, result
// back-pressure and long runs of random traffic with random idling on both
// sides.
// ----------------------------------------------------------------------------
module tb_bitmap_first_fit_allocator_core;
    import bfa_pkg::*;

    localparam int POOL        = POOL_BYTES_DFLT;
    localparam int WORD        = WORD_BYTES_DFLT;
    localparam int SETTLE_CYC  = 300;   // longer than the slowest allocate
    localparam logic [APB_AW-1:0] MAX_REQ_ADDR = {CFG_MAX_REQ, 2'b00};

    typedef struct packed {
        t_status              status;
        logic [OFFSET_W-1:0]  start;
        logic [COUNT_W-1:0]   used;
    } alloc_reply_t;

    typedef struct packed {
        logic [OFFSET_W-1:0]  base;
        logic [SIZE_W-1:0]    len;
    } live_block_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_req_type;
    logic [SIZE_W-1:0]     i_size_bytes;
    logic [OFFSET_W-1:0]   i_block_offset;
    logic                  o_valid;
    logic                  i_ready;
    logic [1:0]            o_status;
    logic [OFFSET_W-1:0]   o_start_offset;
    logic [COUNT_W-1:0]    o_bytes_used;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    // predictor state
    bit                    byte_busy [POOL];
    int                    bytes_in_use;
    int                    size_limit;

    alloc_reply_t          pending_replies [$];
    live_block_t           live_blocks [$];
    alloc_reply_t          checked_reply;
    int                    error_count;
    int                    result_count;
    bit                    tx_idle_en;
    bit                    rx_idle_en;
    int                    rx_hold_req;
    int                    rx_wait;

    bitmap_first_fit_allocator_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_size_bytes   (i_size_bytes),
        .i_block_offset (i_block_offset),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_start_offset (o_start_offset),
        .o_bytes_used   (o_bytes_used),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    initial begin
        #(50_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        $display("result %0d: %s", result_count, msg);
        error_count++;
    endtask

    function automatic int round_up(input logic [SIZE_W-1:0] size);
        return ((int'(size) + WORD - 1) / WORD) * WORD;
    endfunction

    // First-fit allocate / free on the local map; returns the expected word.
    function automatic alloc_reply_t predict_request(input logic kind,
                                                     input logic [SIZE_W-1:0] size,
                                                     input logic [OFFSET_W-1:0] offset);
        alloc_reply_t r;
        int need;
        int run;
        int run_base;
        int i;
        bit placed;
        r.status = STAT_DONE;
        r.start  = '0;
        if (kind == REQ_ALLOC) begin
            if (size == 0 || int'(size) > size_limit) begin
                r.status = STAT_REJECT;
            end else begin
                need     = round_up(size);
                run      = 0;
                run_base = 0;
                placed   = 1'b0;
                for (i = 0; i < POOL && !placed; i++) begin
                    if (!byte_busy[i]) begin
                        if (run == 0)
                            run_base = i;
                        run++;
                        if (run >= need)
                            placed = 1'b1;
                    end else begin
                        run = 0;
                    end
                end
                if (placed) begin
                    for (i = run_base; i < run_base + need; i++)
                        byte_busy[i] = 1'b1;
                    bytes_in_use += need;
                    if (bytes_in_use > COUNT_MAX)
                        bytes_in_use = COUNT_MAX;
                    r.start = run_base[OFFSET_W-1:0];
                end else begin
                    r.status = STAT_NO_SPACE;
                end
            end
        end else if (size == 0) begin
            r.status = STAT_IGNORED;
        end else begin
            need = round_up(size);
            for (i = int'(offset); i < int'(offset) + need && i < POOL; i++)
                byte_busy[i] = 1'b0;
            bytes_in_use = (bytes_in_use > need) ? bytes_in_use - need : 0;
        end
        r.used = bytes_in_use[COUNT_W-1:0];
        return r;
    endfunction

    task automatic send_request(input logic kind, input logic [SIZE_W-1:0] size,
                                input logic [OFFSET_W-1:0] offset);
        int gap;
        alloc_reply_t reply;
        gap = tx_idle_en ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_req_type     <= kind;
        i_size_bytes   <= size;
        i_block_offset <= offset;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        reply = predict_request(kind, size, offset);
        pending_replies.push_back(reply);
        if (kind == REQ_ALLOC && reply.status == STAT_DONE)
            live_blocks.push_back('{base: reply.start, len: size});
    endtask

    // sender stops and waits until every result word is back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_size_limit(input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MAX_REQ_ADDR;
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        size_limit = value & COUNT_MAX;
        @(posedge i_clk);
    endtask

    // receiver: random stall after each word, plus an optional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (rx_hold_req > 0) begin
                rx_wait = rx_hold_req;
                rx_hold_req = 0;
            end else if (o_valid && i_ready) begin
                rx_wait = rx_idle_en ? $urandom_range(0, 17) : 0;
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            i_ready <= (rx_wait == 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_replies.size() == 0) begin
                flag_mismatch($sformatf("unexpected word, status %0d", o_status));
            end else begin
                checked_reply = pending_replies.pop_front();
                if (o_status !== checked_reply.status)
                    flag_mismatch($sformatf("status %0d, want %0d",
                                            o_status, checked_reply.status));
                if (o_start_offset !== checked_reply.start)
                    flag_mismatch($sformatf("start_offset %0d, want %0d",
                                            o_start_offset, checked_reply.start));
                if (o_bytes_used !== checked_reply.used)
                    flag_mismatch($sformatf("bytes_used %0d, want %0d",
                                            o_bytes_used, checked_reply.used));
            end
            result_count++;
        end
    end

    task automatic test_directed_cases();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        send_request(REQ_ALLOC, 16'd0,     12'd0);      // zero size rejected
        send_request(REQ_ALLOC, 16'd1,     12'd4095);   // rounds up to one word
        send_request(REQ_ALLOC, 16'd3,     12'd0);
        send_request(REQ_ALLOC, 16'd1024,  12'd0);      // exactly at the limit
        send_request(REQ_ALLOC, 16'd1025,  12'd0);
        send_request(REQ_ALLOC, 16'hFFFF,  12'd0);
        send_request(REQ_FREE,  16'd0,     12'd4095);   // ignored
        send_request(REQ_FREE,  16'd4,     12'd2);
        send_request(REQ_ALLOC, 16'd4,     12'd0);      // reuses the hole
        send_request(REQ_FREE,  16'd100,   12'd4095);   // runs off the pool end
        send_request(REQ_FREE,  16'd8,     12'd3000);   // bytes never in use
        send_request(REQ_FREE,  16'hFFFF,  12'd0);      // count hits zero
        repeat (4) send_request(REQ_ALLOC, 16'd1024, 12'd0);
        send_request(REQ_ALLOC, 16'd2,     12'd0);      // pool full
        send_request(REQ_FREE,  16'd1023,  12'd1024);
        send_request(REQ_ALLOC, 16'd1000,  12'd0);
        send_request(REQ_ALLOC, 16'd30,    12'd0);
        send_request(REQ_FREE,  16'hFFFF,  12'd0);
        drain_results();
    endtask

    task automatic test_limit_extremes();
        write_size_limit(4096);
        send_request(REQ_ALLOC, 16'd4096,  12'd0);
        send_request(REQ_ALLOC, 16'd4097,  12'd0);
        send_request(REQ_FREE,  16'd4096,  12'd0);
        drain_results();
        write_size_limit(COUNT_MAX);
        send_request(REQ_ALLOC, 16'd8191,  12'd0);      // larger than the pool
        send_request(REQ_ALLOC, 16'd4097,  12'd0);
        send_request(REQ_ALLOC, 16'd8192,  12'd0);
        drain_results();
        write_size_limit(0);                            // every allocate rejected
        send_request(REQ_ALLOC, 16'd1,     12'd0);
        send_request(REQ_ALLOC, 16'd0,     12'd0);
        send_request(REQ_FREE,  16'd8,     12'd0);
        drain_results();
        write_size_limit(1);
        send_request(REQ_ALLOC, 16'd1,     12'd0);
        send_request(REQ_ALLOC, 16'd2,     12'd0);
        send_request(REQ_FREE,  16'd1,     12'd0);
        drain_results();
    endtask

    // result side held off while quick requests keep coming, so input stalls
    task automatic test_backpressure();
        int n;
        write_size_limit(LIMIT_RST);
        tx_idle_en  = 1'b0;
        rx_hold_req = 400;
        for (n = 0; n < 16; n++) begin
            if (n[0])
                send_request(REQ_FREE, 16'd0, 12'($urandom_range(0, 4095)));
            else
                send_request(REQ_ALLOC, 16'd0, 12'($urandom_range(0, 4095)));
        end
        drain_results();
    endtask

    task automatic test_random_traffic(input int limit, input int count,
                                       input bit tx_idle, input bit rx_idle);
        int n;
        int pick;
        int idx;
        logic kind;
        logic [SIZE_W-1:0] size;
        logic [OFFSET_W-1:0] offset;
        live_block_t blk;
        write_size_limit(limit);
        tx_idle_en = tx_idle;
        rx_idle_en = rx_idle;
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (bytes_in_use > 3000 && pick < 50)
                pick += 50;
            if (pick < 55) begin
                kind   = REQ_ALLOC;
                offset = OFFSET_W'($urandom_range(0, 4095));
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6: size = SIZE_W'($urandom_range(1, 64));
                    7, 8:    size = SIZE_W'($urandom_range(1, (size_limit > 1) ? size_limit : 1));
                    default: begin
                        case ($urandom_range(0, 3))
                            0:       size = '0;
                            1:       size = SIZE_W'(size_limit);
                            2:       size = SIZE_W'(size_limit + 1);
                            default: size = SIZE_W'($urandom);
                        endcase
                    end
                endcase
            end else if (pick < 85 && live_blocks.size() > 0) begin
                kind   = REQ_FREE;
                idx    = $urandom_range(0, live_blocks.size() - 1);
                blk    = live_blocks[idx];
                live_blocks.delete(idx);
                offset = blk.base;
                size   = ($urandom_range(0, 4) == 0) ?
                         SIZE_W'($urandom_range(1, int'(blk.len) + 16)) : blk.len;
            end else begin
                kind   = REQ_FREE;
                offset = OFFSET_W'($urandom_range(0, 4095));
                case ($urandom_range(0, 3))
                    0:       size = '0;
                    1, 2:    size = SIZE_W'($urandom_range(1, 64));
                    default: size = SIZE_W'($urandom);
                endcase
            end
            send_request(kind, size, offset);
        end
        drain_results();
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_req_type     <= REQ_ALLOC;
        i_size_bytes   <= '0;
        i_block_offset <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        error_count    = 0;
        result_count   = 0;
        rx_hold_req    = 0;
        bytes_in_use   = 0;
        size_limit     = LIMIT_RST;
        tx_idle_en     = 1'b1;
        rx_idle_en     = 1'b1;
        foreach (byte_busy[i])
            byte_busy[i] = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_limit_extremes();
        test_backpressure();
        test_random_traffic(LIMIT_RST, 250, 1'b1, 1'b1);
        test_random_traffic(4096,      200, 1'b0, 1'b1);
        test_random_traffic(64,        200, 1'b1, 1'b0);
        test_random_traffic(1,         100, 1'b1, 1'b1);
        test_random_traffic(COUNT_MAX, 200, 1'b0, 1'b0);
        test_random_traffic(0,          50, 1'b1, 1'b1);
        test_random_traffic(300,       200, 1'b1, 1'b1);

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[bitmap_first_fit_allocator_core.f]
+incdir+sv
sv/bfa_pkg.sv
sv/bitmap_first_fit_allocator_core.sv
sv/bfa_checker.sv
tb/tb_bitmap_first_fit_allocator_core.sv
